// ===== hw/rtl/pfe_pkg.sv =====
// Shared constants, codes and control types of the palette fade engine.
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  // Fixed field widths of the item, result and register interfaces.
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned IDX_W       = 10;
  localparam int unsigned LEVEL_W     = 6;
  localparam int unsigned OUT_LEVEL_W = 8;
  localparam int unsigned STEP_W      = 8;
  localparam int unsigned GAMMA_W     = 5;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  // Register values after reset.
  localparam logic [STEP_W-1:0]  STEP_COUNT_RST = 8'd32;
  localparam logic [GAMMA_W-1:0] GAMMA_RST      = 5'd0;
  localparam logic               DIRECTION_RST  = 1'b0;

  // Item kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD   = 2'd0,
    KIND_STEP   = 2'd1,
    KIND_FINISH = 2'd2
  } pfe_kind_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP_COUNT = 2'd0,
    CFG_GAMMA      = 2'd1,
    CFG_DIRECTION  = 2'd2
  } pfe_cfg_e;

  // Control of the bit-serial accumulator update unit.
  typedef struct packed {
    logic start;
    logic sub;
  } pfe_ser_ctrl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/pfe_div.sv =====
// Bit-serial restoring divider that forms the per-step delta of a load.
`timescale 1ns / 1ps
`default_nettype none

module pfe_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start_i,
  input  wire logic [pfe_pkg::LEVEL_W-1:0]    level_i,
  input  wire logic [pfe_pkg::STEP_W-1:0]     divisor_i,
  output logic                                done_o,
  output logic [pfe_pkg::LEVEL_W+FRAC_BITS-1:0] quotient_o
);
  import pfe_pkg::*;

  localparam int unsigned ACC_W = LEVEL_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0]  dvd_q, dvd_d;
  logic [STEP_W-1:0] rem_q, rem_d;
  logic [STEP_W-1:0] div_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   diff;
  logic              ge;

  // One quotient bit per cycle: shift the next dividend bit into the
  // remainder and subtract the divisor where it fits.
  always_comb begin
    trial = {rem_q, dvd_q[ACC_W-1]};
    diff  = trial - {1'b0, div_q};
    ge    = (trial >= {1'b0, div_q});
    rem_d = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
    dvd_d = {dvd_q[ACC_W-2:0], ge};
  end

  // Sequencing of the iterations.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Dividend and remainder shift registers and the divisor register; the quotient fills
  // the dividend register from the bottom.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {level_i, {FRAC_BITS{1'b0}}};
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = dvd_q;

endmodule

`default_nettype wire

// ===== hw/rtl/pfe_ser.sv =====
// Bit-serial add or subtract of the delta with saturation and ceiling clamp.
`timescale 1ns / 1ps
`default_nettype none

module pfe_ser #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire pfe_pkg::pfe_ser_ctrl_t           ctrl_i,
  input  wire logic [pfe_pkg::LEVEL_W+FRAC_BITS-1:0] acc_i,
  input  wire logic [pfe_pkg::LEVEL_W+FRAC_BITS-1:0] delta_i,
  input  wire logic [pfe_pkg::LEVEL_W+FRAC_BITS-1:0] ceil_i,
  output logic                                  done_o,
  output logic [pfe_pkg::LEVEL_W+FRAC_BITS-1:0] result_o
);
  import pfe_pkg::*;

  localparam int unsigned ACC_W = LEVEL_W + FRAC_BITS;
  localparam int unsigned CNT_W = $clog2(ACC_W);

  logic [ACC_W-1:0] a_q, b_q, c_q, r_q;
  logic             cy_q, gt_q, sub_q;
  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic             a0, b0, c0, s, cy_n, gt_n;

  // One bit of the sum or difference per cycle, LSB first, with a running
  // comparison of the result against the ceiling.
  always_comb begin
    a0   = a_q[0];
    b0   = b_q[0];
    c0   = c_q[0];
    s    = a0 ^ b0 ^ cy_q;
    cy_n = sub_q ? ((~a0 & b0) | (~(a0 ^ b0) & cy_q))
                 : ((a0 & b0) | (cy_q & (a0 ^ b0)));
    gt_n = (s != c0) ? s : gt_q;
  end

  // Sequencing of the bit steps.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operand and result shift registers. The ceiling rotates so that it is
  // whole again when the last bit has been processed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      a_q   <= acc_i;
      b_q   <= delta_i;
      c_q   <= ceil_i;
      cy_q  <= 1'b0;
      gt_q  <= 1'b0;
      sub_q <= ctrl_i.sub;
    end else if (busy_q) begin
      a_q  <= {1'b0, a_q[ACC_W-1:1]};
      b_q  <= {1'b0, b_q[ACC_W-1:1]};
      c_q  <= {c0, c_q[ACC_W-1:1]};
      r_q  <= {s, r_q[ACC_W-1:1]};
      cy_q <= cy_n;
      gt_q <= gt_n;
    end
  end

  // A final borrow means underflow to zero; a final carry means overflow,
  // which the ceiling then bounds. Otherwise the ceiling clamps the result.
  always_comb begin
    if (cy_q) begin
      result_o = sub_q ? '0 : c_q;
    end else begin
      result_o = gt_q ? c_q : r_q;
    end
  end

  assign done_o = done_q;

endmodule

`default_nettype wire

// ===== hw/rtl/palette_fade_engine.sv =====
// Palette fade engine: component stores, control sequencer and result register.
`timescale 1ns / 1ps
`default_nettype none

// Linear palette fader over NUM_COMPONENTS six-bit color components. A load
// transaction records a target level and computes its per-step delta with a
// bit-serial divider that produces one quotient bit per cycle, and it
// occupies the block until the divider has finished.
// A step transaction reads the component, runs the accumulator update through
// a bit-serial adder one bit per cycle and writes it back before the next
// transaction can enter; its result waits in an output register, so the block
// is free again while the result is still stalled, unless the next step also
// needs that register. Finish and ignored transactions do not leave the idle
// state. The component stores are not cleared by reset; stepping a component
// that was never loaded returns an undefined level.
module palette_fade_engine #(
  parameter int unsigned NUM_COMPONENTS = 768,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [pfe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [pfe_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic [pfe_pkg::KIND_W-1:0]      kind_i,
  input  wire logic [pfe_pkg::IDX_W-1:0]       component_index_i,
  input  wire logic [pfe_pkg::LEVEL_W-1:0]     target_level_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [pfe_pkg::IDX_W-1:0]            out_index_o,
  output logic [pfe_pkg::OUT_LEVEL_W-1:0]      out_level_o
);
  import pfe_pkg::*;

  localparam int unsigned ACC_W = LEVEL_W + FRAC_BITS;
  localparam int unsigned AW    = $clog2(NUM_COMPONENTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_READ = 3'd2;
  localparam logic [2:0] S_SER  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  // Configuration and fade flag.
  logic [STEP_W-1:0]  step_count_q;
  logic [GAMMA_W-1:0] gamma_q;
  logic               fade_dir_q;
  logic               faded_q, faded_d;

  // Sequencer and transaction latches.
  logic [2:0]         state_q, state_d;
  logic [IDX_W-1:0]   idx_q;
  logic [LEVEL_W-1:0] tgt_q;
  logic               accept, in_range, allowed, go_load, go_step;
  logic [AW-1:0]      rd_addr, wr_addr;

  // Component stores and their registered read data.
  logic [LEVEL_W-1:0] target_mem [NUM_COMPONENTS];
  logic [ACC_W-1:0]   delta_mem  [NUM_COMPONENTS];
  logic [ACC_W-1:0]   accum_mem  [NUM_COMPONENTS];
  logic [LEVEL_W-1:0] tgt_rd_q;
  logic [ACC_W-1:0]   delta_rd_q;
  logic [ACC_W-1:0]   acc_rd_q;

  // Serial units.
  logic [STEP_W-1:0]  divisor;
  logic               div_done;
  logic [ACC_W-1:0]   quotient;
  pfe_ser_ctrl_t      ser_ctrl;
  logic               ser_done;
  logic [ACC_W-1:0]   ser_result;
  logic [LEVEL_W:0]   ceil_sum;
  logic [ACC_W-1:0]   ceil;

  // Result staging and output register.
  logic [LEVEL_W-1:0] res_level_q;
  logic               out_valid_q;
  logic [IDX_W-1:0]   out_index_q;
  logic [LEVEL_W-1:0] out_level_q;
  logic               out_load;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= STEP_COUNT_RST;
      gamma_q      <= GAMMA_RST;
      fade_dir_q   <= DIRECTION_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STEP_COUNT: step_count_q <= cfg_wdata_i[STEP_W-1:0];
        CFG_GAMMA:      gamma_q      <= cfg_wdata_i[GAMMA_W-1:0];
        CFG_DIRECTION:  fade_dir_q   <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Transaction decode.
  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign in_range   = (32'(component_index_i) < NUM_COMPONENTS);
  assign allowed    = fade_dir_q ? ~faded_q : faded_q;
  assign go_load    = accept & (kind_i == KIND_LOAD) & allowed & in_range;
  assign go_step    = accept & (kind_i == KIND_STEP) & allowed & in_range;
  assign rd_addr    = AW'(component_index_i);
  assign wr_addr    = AW'(idx_q);
  assign out_load   = (state_q == S_OUT) & (~out_valid_q | ~out_stall_i);

  // A finish transaction records the current direction.
  always_comb begin
    faded_d = faded_q;
    if (accept && (kind_i == KIND_FINISH)) begin
      faded_d = fade_dir_q;
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (go_load) begin
          state_d = S_DIV;
        end else if (go_step) begin
          state_d = S_READ;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_IDLE;
        end
      end
      S_READ: state_d = S_SER;
      S_SER: begin
        if (ser_done) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      faded_q <= 1'b0;
    end else begin
      state_q <= state_d;
      faded_q <= faded_d;
    end
  end

  // Transaction payload latches.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= component_index_i;
      tgt_q <= target_level_i;
    end
  end

  // Store reads start with the accepted step transaction.
  always_ff @(posedge clk_i) begin
    if (go_step) begin
      tgt_rd_q   <= target_mem[rd_addr];
      delta_rd_q <= delta_mem[rd_addr];
      acc_rd_q   <= accum_mem[rd_addr];
    end
  end

  // Store writes: a load fills all three, a step writes the accumulator back.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_DIV) && div_done) begin
      target_mem[wr_addr] <= tgt_q;
      delta_mem[wr_addr]  <= quotient;
      accum_mem[wr_addr]  <= fade_dir_q ? {tgt_q, {FRAC_BITS{1'b0}}} : '0;
    end else if ((state_q == S_SER) && ser_done) begin
      accum_mem[wr_addr]  <= ser_result;
    end
  end

  // Delta divider; a step count of zero divides by one.
  assign divisor = (step_count_q == '0) ? STEP_W'(1) : step_count_q;

  pfe_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_load),
    .level_i    (target_level_i),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Clamp ceiling: target plus gamma, saturated to the accumulator range.
  always_comb begin
    ceil_sum = {1'b0, tgt_rd_q} + {{(LEVEL_W + 1 - GAMMA_W){1'b0}}, gamma_q};
    ceil     = ceil_sum[LEVEL_W] ? {ACC_W{1'b1}}
                                 : {ceil_sum[LEVEL_W-1:0], {FRAC_BITS{1'b0}}};
  end

  assign ser_ctrl.start = (state_q == S_READ);
  assign ser_ctrl.sub   = fade_dir_q;

  pfe_ser #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ser_ctrl),
    .acc_i    (acc_rd_q),
    .delta_i  (delta_rd_q),
    .ceil_i   (ceil),
    .done_o   (ser_done),
    .result_o (ser_result)
  );

  // The integer part of the accumulator never exceeds the top level.
  always_ff @(posedge clk_i) begin
    if ((state_q == S_SER) && ser_done) begin
      res_level_q <= ser_result[ACC_W-1:FRAC_BITS];
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= idx_q;
      out_level_q <= res_level_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign out_level_o = {out_level_q, {(OUT_LEVEL_W - LEVEL_W){1'b0}}};

  // The divider only finishes while a load is waiting for it.
  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside of a load");

  // The serial adder only finishes while a step is waiting for it.
  a_ser_done_in_ser : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ser_done |-> (state_q == S_SER))
    else $error("serial update finished outside of a step");

  // A new result only appears after the sequencer has handed one over.
  a_out_from_seq : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_OUT))
    else $error("result appeared without a finished step");

  // An accepted and permitted step goes on to read the stores.
  a_step_reads : assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_step |=> (state_q == S_READ))
    else $error("permitted step did not start a store read");

endmodule

`default_nettype wire
